>>> hw/rtl/whmf_pkg.sv
// package: widths, payload and status types, register codes for the motion filter
`timescale 1ns / 1ps

package whmf_pkg;

	localparam int HISTORY_DEPTH = 10;

	localparam int SAMPLE_W = 16;
	localparam int OUT_W    = 24;
	localparam int FRAC_W   = 8;
	localparam int WEIGHT_W = 16;

	localparam int IDX_W = $clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2);
	localparam int ACC_W = 34 + $clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2);
	localparam int TOT_W = 18 + $clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2);
	localparam int NUM_W = ACC_W + FRAC_W;
	localparam int DIV_W = (NUM_W + 1 > TOT_W + OUT_W) ? NUM_W + 1 : TOT_W + OUT_W;
	localparam int QUO_W  = OUT_W + 1;
	localparam int QCNT_W = $clog2(QUO_W + 1);

	localparam logic [TOT_W-1:0] ONE_Q16 = TOT_W'(65536);
	localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
	localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FACTOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd1;
	localparam logic [WEIGHT_W-1:0] WEIGHT_FACTOR_RESET = 16'd13107;
	localparam logic FILTER_ENABLE_RESET = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] delta_x;
		logic signed [SAMPLE_W-1:0] delta_y;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] smooth_x;
		logic signed [OUT_W-1:0] smooth_y;
	} out_item_t;

	typedef struct packed {
		logic                    done;
		logic signed [OUT_W-1:0] weighted;
	} div_res_t;

endpackage

>>> hw/rtl/whmf_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module whmf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]    raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/whmf_div.sv
// serial rounding divider: weighted sum times 256 over total weight, saturated to 24 bits
`timescale 1ns / 1ps

module whmf_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [whmf_pkg::ACC_W-1:0]     acc,
	input  logic [whmf_pkg::TOT_W-1:0]            total,
	output whmf_pkg::div_res_t                    result
);

	logic                              busy_q;
	logic                              done_q;
	logic [whmf_pkg::QCNT_W-1:0]       cnt_q;
	logic [whmf_pkg::DIV_W-1:0]        rem_q;
	logic [whmf_pkg::DIV_W-1:0]        dsh_q;
	logic [whmf_pkg::QUO_W-1:0]        quo_q;
	logic                              neg_q;
	logic signed [whmf_pkg::OUT_W-1:0] weighted_q;

	logic signed [whmf_pkg::NUM_W-1:0] num;
	logic [whmf_pkg::NUM_W-1:0]        mag;
	logic                              take;
	logic signed [whmf_pkg::OUT_W-1:0] sat_val;

	assign num  = {acc, {whmf_pkg::FRAC_W{1'b0}}};
	assign mag  = num[whmf_pkg::NUM_W-1] ? (~num + 1'b1) : num;
	assign take = (rem_q >= dsh_q);

	always_comb begin
		if (neg_q) begin
			if (quo_q > whmf_pkg::QUO_W'(24'h800000)) begin
				sat_val = whmf_pkg::OUT_MIN;
			end else begin
				sat_val = -$signed(quo_q[whmf_pkg::OUT_W-1:0]);
			end
		end else begin
			if (quo_q > whmf_pkg::QUO_W'(24'h7FFFFF)) begin
				sat_val = whmf_pkg::OUT_MAX;
			end else begin
				sat_val = $signed(quo_q[whmf_pkg::OUT_W-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= whmf_pkg::QCNT_W'(whmf_pkg::QUO_W);
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= whmf_pkg::DIV_W'(mag) + whmf_pkg::DIV_W'(total >> 1);
			dsh_q <= whmf_pkg::DIV_W'({total, {whmf_pkg::OUT_W{1'b0}}});
			neg_q <= acc[whmf_pkg::ACC_W-1];
			quo_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (take) begin
					rem_q <= rem_q - dsh_q;
				end
				quo_q <= {quo_q[whmf_pkg::QUO_W-2:0], take};
				dsh_q <= dsh_q >> 1;
			end else begin
				weighted_q <= sat_val;
			end
		end
	end

	assign result.done     = done_q;
	assign result.weighted = weighted_q;

endmodule

>>> hw/rtl/weighted_history_motion_filter.sv
// top level: history ram, multiply-accumulate over taps, dividers, two-tap mean, output register
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    in_data (delta_x, delta_y)
// out       output     out_valid / out_ready  out_data (smooth_x, smooth_y)
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// filtered item: one ram read per older history tap, then a 25-step restoring divider per axis;
// a pass-through item goes straight from the idle state to the done state
// one item in flight at a time; in_ready is high in the idle state, also while the output register holds a result
// a finished result stalls in its holding register until the output register is free
// reset clears the history valid bits and last weighted values and loads the config registers with their reset values
`timescale 1ns / 1ps

module weighted_history_motion_filter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  whmf_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output whmf_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [whmf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [whmf_pkg::CFG_DATA_W-1:0]    cfg_data
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MAC  = 5'b00010,
		S_DIV  = 5'b00100,
		S_DONE = 5'b01000,
		S_SPARE = 5'b10000
	} state_t;

	localparam logic [whmf_pkg::IDX_W-1:0] LAST_IDX = whmf_pkg::IDX_W'(whmf_pkg::HISTORY_DEPTH - 1);

	state_t                                state_q;
	logic [whmf_pkg::WEIGHT_W-1:0]         factor_q;
	logic                                  enable_q;
	logic [whmf_pkg::IDX_W-1:0]            head_q;
	logic [whmf_pkg::IDX_W-1:0]            rd_addr_q;
	logic [whmf_pkg::IDX_W-1:0]            issue_cnt_q;
	logic [whmf_pkg::HISTORY_DEPTH-1:0]    valid_q;
	logic                                  rd_valid_s1;
	logic                                  ent_valid_s1;
	logic [whmf_pkg::WEIGHT_W-1:0]         w_q;
	logic signed [whmf_pkg::ACC_W-1:0]     acc_x_q;
	logic signed [whmf_pkg::ACC_W-1:0]     acc_y_q;
	logic [whmf_pkg::TOT_W-1:0]            total_q;
	logic signed [whmf_pkg::OUT_W-1:0]     last_x_q;
	logic signed [whmf_pkg::OUT_W-1:0]     last_y_q;
	whmf_pkg::out_item_t                   res_q;
	whmf_pkg::out_item_t                   out_q;
	logic                                  out_valid_q;

	logic                                  in_xfer;
	logic [whmf_pkg::IDX_W-1:0]            head_new;
	logic [whmf_pkg::IDX_W-1:0]            first_rd;
	logic                                  ram_re;
	logic [2*whmf_pkg::SAMPLE_W-1:0]       ram_rdata;
	logic signed [whmf_pkg::SAMPLE_W-1:0]  tap_x;
	logic signed [whmf_pkg::SAMPLE_W-1:0]  tap_y;
	logic signed [32:0]                    prod_x;
	logic signed [32:0]                    prod_y;
	logic [31:0]                           w_prod;
	logic                                  div_start;
	whmf_pkg::div_res_t                    div_x;
	whmf_pkg::div_res_t                    div_y;
	logic signed [whmf_pkg::OUT_W-1:0]     mean_x;
	logic signed [whmf_pkg::OUT_W-1:0]     mean_y;
	logic                                  out_free;

	function automatic logic signed [whmf_pkg::OUT_W-1:0] mean2(
		input logic signed [whmf_pkg::OUT_W-1:0] a,
		input logic signed [whmf_pkg::OUT_W-1:0] b
	);
		logic signed [whmf_pkg::OUT_W:0] sum;
		logic [whmf_pkg::OUT_W:0]        mag;
		logic [whmf_pkg::OUT_W:0]        half;
		sum  = $signed({a[whmf_pkg::OUT_W-1], a}) + $signed({b[whmf_pkg::OUT_W-1], b});
		mag  = sum[whmf_pkg::OUT_W] ? (~sum + 1'b1) : sum;
		half = (mag + 1'b1) >> 1;
		if (sum[whmf_pkg::OUT_W]) begin
			mean2 = whmf_pkg::OUT_W'(~half + 1'b1);
		end else begin
			mean2 = whmf_pkg::OUT_W'(half);
		end
	endfunction

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign head_new = (head_q == '0) ? LAST_IDX : head_q - 1'b1;
	assign first_rd = (head_new == LAST_IDX) ? '0 : head_new + 1'b1;

	assign ram_re = (state_q == S_MAC) && (issue_cnt_q != '0);

	whmf_ram #(
		.WIDTH (2 * whmf_pkg::SAMPLE_W),
		.DEPTH (whmf_pkg::HISTORY_DEPTH)
	) u_hist_ram (
		.clk   (clk),
		.we    (in_xfer && enable_q),
		.waddr (head_new),
		.wdata ({in_data.delta_y, in_data.delta_x}),
		.re    (ram_re),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	// entries never written read as zero
	assign tap_x = ent_valid_s1 ? $signed(ram_rdata[whmf_pkg::SAMPLE_W-1:0]) : '0;
	assign tap_y = ent_valid_s1 ? $signed(ram_rdata[2*whmf_pkg::SAMPLE_W-1:whmf_pkg::SAMPLE_W]) : '0;

	assign prod_x = tap_x * $signed({1'b0, w_q});
	assign prod_y = tap_y * $signed({1'b0, w_q});
	assign w_prod = w_q * factor_q;

	assign div_start = (state_q == S_MAC) && (issue_cnt_q == '0) && !rd_valid_s1;

	whmf_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.acc    (acc_x_q),
		.total  (total_q),
		.result (div_x)
	);

	whmf_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.acc    (acc_y_q),
		.total  (total_q),
		.result (div_y)
	);

	assign mean_x = mean2(div_x.weighted, last_x_q);
	assign mean_y = mean2(div_y.weighted, last_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			factor_q    <= whmf_pkg::WEIGHT_FACTOR_RESET;
			enable_q    <= whmf_pkg::FILTER_ENABLE_RESET;
			head_q      <= '0;
			valid_q     <= '0;
			issue_cnt_q <= '0;
			rd_valid_s1 <= 1'b0;
			last_x_q    <= '0;
			last_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					whmf_pkg::REG_WEIGHT_FACTOR: begin
						factor_q <= cfg_data;
					end
					whmf_pkg::REG_FILTER_ENABLE: begin
						enable_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end

			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			rd_valid_s1 <= ram_re;

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (enable_q) begin
							head_q           <= head_new;
							valid_q[head_new] <= 1'b1;
							issue_cnt_q      <= whmf_pkg::IDX_W'(whmf_pkg::HISTORY_DEPTH - 1);
							state_q          <= S_MAC;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MAC: begin
					if (ram_re) begin
						issue_cnt_q <= issue_cnt_q - 1'b1;
					end
					if (div_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_x.done) begin
						last_x_q <= div_x.weighted;
						last_y_q <= div_y.weighted;
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					acc_x_q   <= whmf_pkg::ACC_W'($signed({in_data.delta_x, 16'b0}));
					acc_y_q   <= whmf_pkg::ACC_W'($signed({in_data.delta_y, 16'b0}));
					total_q   <= whmf_pkg::ONE_Q16;
					w_q       <= factor_q;
					rd_addr_q <= first_rd;
					res_q.smooth_x <= {in_data.delta_x, {whmf_pkg::FRAC_W{1'b0}}};
					res_q.smooth_y <= {in_data.delta_y, {whmf_pkg::FRAC_W{1'b0}}};
				end
			end
			S_MAC: begin
				if (ram_re) begin
					ent_valid_s1 <= valid_q[rd_addr_q];
					rd_addr_q    <= (rd_addr_q == LAST_IDX) ? '0 : rd_addr_q + 1'b1;
				end
				if (rd_valid_s1) begin
					acc_x_q <= acc_x_q + whmf_pkg::ACC_W'(prod_x);
					acc_y_q <= acc_y_q + whmf_pkg::ACC_W'(prod_y);
					total_q <= total_q + whmf_pkg::TOT_W'(w_q);
					w_q     <= w_prod[31:16];
				end
			end
			S_DIV: begin
				if (div_x.done) begin
					res_q.smooth_x <= mean_x;
					res_q.smooth_y <= mean_y;
				end
			end
			default: begin
			end
		endcase

		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		div_x.done == div_y.done)
		else $error("axis dividers out of step");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_x.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && enable_q) |=> valid_q[head_q])
		else $error("history entry not marked valid after write");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (total_q >= whmf_pkg::ONE_Q16))
		else $error("total weight below one at divide start");
`endif

endmodule
